// ===== src/gpsinfo_pkg.sv =====
// gpsinfo_pkg: shared types, character codes, field positions and scaling tables
// for the gps info line parser. No dependencies.
package gpsinfo_pkg;

    // line layout
    localparam int unsigned PREFIX_LEN      = 11;
    localparam logic [5:0]  POS_LAT_DEG     = 6'd11;
    localparam logic [5:0]  POS_LAT_DEG_END = 6'd12;
    localparam logic [5:0]  POS_LAT_MIN     = 6'd13;
    localparam logic [5:0]  POS_LAT_MIN_END = 6'd21;
    localparam logic [5:0]  POS_LAT_HEMI    = 6'd23;
    localparam logic [5:0]  POS_LON_DEG     = 6'd25;
    localparam logic [5:0]  POS_LON_DEG_END = 6'd27;
    localparam logic [5:0]  POS_LON_MIN     = 6'd28;
    localparam logic [5:0]  POS_LON_MIN_END = 6'd36;
    localparam logic [5:0]  POS_LON_HEMI    = 6'd38;
    localparam logic [5:0]  POS_FULL_LINE   = 6'd39;
    localparam logic [5:0]  POS_MAX         = 6'd63;

    // character codes
    localparam logic [7:0] CH_0   = 8'h30;
    localparam logic [7:0] CH_9   = 8'h39;
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_N   = 8'h4E;
    localparam logic [7:0] CH_S   = 8'h53;
    localparam logic [7:0] CH_E   = 8'h45;
    localparam logic [7:0] CH_W   = 8'h57;

    // limits in 1e-7 degree
    localparam logic [29:0] LAT_LIMIT = 30'd900000000;
    localparam logic [30:0] LON_LIMIT = 31'd1800000000;
    localparam logic [31:0] LON_RESET = 32'd1800000000;

    // one degree in 1e-7 degree
    localparam logic [23:0] DEG_UNIT = 24'd10000000;

    // minutes are kept as X = digits * 10^(8-frac) in 1e-8 minute, held as
    // X = 600*q + r; a new digit adds d*10^e = 600*(d*MIN_Q[e]) + d*MIN_R[e]
    localparam logic [9:0] MIN_DIV      = 10'd600;
    localparam logic [9:0] MIN_HALF     = 10'd300;
    localparam logic [3:0] EXP_NO_DOT   = 4'd8;
    localparam logic [3:0] EXP_TOP_FRAC = 4'd7;
    localparam logic [17:0] MIN_Q [0:8] = '{
        18'd0, 18'd0, 18'd0, 18'd1, 18'd16, 18'd166, 18'd1666, 18'd16666, 18'd166666
    };
    localparam logic [9:0] MIN_R [0:8] = '{
        10'd1, 10'd10, 10'd100, 10'd400, 10'd400, 10'd400, 10'd400, 10'd400, 10'd400
    };

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_PREFIX = 3'd1,
        ST_BAD_NS = 3'd2,
        ST_BAD_EW = 3'd3,
        ST_SHORT  = 3'd4
    } t_status;

    // per-byte control for the field accumulator
    typedef struct packed {
        logic en;
        logic clr_deg;
        logic clr_min;
        logic deg_field;
        logic min_field;
    } t_field_ctl;

    function automatic logic [7:0] prefix_char(input logic [3:0] idx);
        logic [7:0] ch;
        unique case (idx)
            4'd0:    ch = 8'h2B; // +
            4'd1:    ch = 8'h43; // C
            4'd2:    ch = 8'h47; // G
            4'd3:    ch = 8'h50; // P
            4'd4:    ch = 8'h53; // S
            4'd5:    ch = 8'h49; // I
            4'd6:    ch = 8'h4E; // N
            4'd7:    ch = 8'h46; // F
            4'd8:    ch = 8'h4F; // O
            4'd9:    ch = 8'h3A; // :
            4'd10:   ch = 8'h20; // space
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // floor(t / 600) for t below 9600, by independent threshold compares
    function automatic logic [3:0] div600_small(input logic [13:0] t);
        logic [3:0] cnt;
        cnt = 4'd0;
        for (int i = 1; i < 16; i++) begin
            cnt = cnt + 4'(t >= 14'(600 * i));
        end
        return cnt;
    endfunction

endpackage

// ===== src/gpsinfo_field_acc.sv =====
// gpsinfo_field_acc: degree and minute accumulators of one coordinate field,
// giving the rounded magnitude in 1e-7 degree. Depends on gpsinfo_pkg.
module gpsinfo_field_acc (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  gpsinfo_pkg::t_field_ctl i_ctl,
    input  logic [7:0]              i_char,
    output logic [48:0]             o_magnitude
);
    import gpsinfo_pkg::*;

    logic [33:0] r_deg, n_deg;      // degrees already scaled by 1e7
    logic [47:0] r_min_q, n_min_q;  // minutes quotient by 600
    logic [9:0]  r_min_r, n_min_r;  // minutes remainder by 600
    logic        r_end, n_end;
    logic        r_dot, n_dot;
    logic [3:0]  r_frac, n_frac;

    logic        is_digit;
    logic [3:0]  digit;
    logic        clr_min_all;
    logic [3:0]  exp_idx;
    logic [13:0] rem_sum;
    logic [3:0]  rem_carry;
    logic [21:0] q_step;
    logic [47:0] q_scaled;
    logic [27:0] deg_step;

    assign is_digit    = (i_char >= CH_0) && (i_char <= CH_9);
    assign digit       = 4'(i_char - CH_0);
    assign clr_min_all = i_ctl.clr_deg || i_ctl.clr_min;

    always_comb begin
        n_deg   = i_ctl.clr_deg ? '0 : r_deg;
        n_min_q = clr_min_all ? '0 : r_min_q;
        n_min_r = clr_min_all ? '0 : r_min_r;
        n_end   = clr_min_all ? 1'b0 : r_end;
        n_dot   = clr_min_all ? 1'b0 : r_dot;
        n_frac  = clr_min_all ? 4'd0 : r_frac;

        deg_step = 28'(digit) * 28'(DEG_UNIT);

        // before the dot a digit shifts everything by ten, after it adds 10^(7-frac)
        if (!n_dot) begin
            exp_idx = EXP_NO_DOT;
        end else if (n_frac <= EXP_TOP_FRAC) begin
            exp_idx = 4'(EXP_TOP_FRAC - n_frac);
        end else begin
            exp_idx = 4'd0;
        end
        rem_sum   = (n_dot ? 14'(n_min_r) : 14'(n_min_r) * 14'd10)
                  + 14'(digit) * 14'(MIN_R[exp_idx]);
        rem_carry = div600_small(rem_sum);
        q_step    = 22'(digit) * 22'(MIN_Q[exp_idx]);
        q_scaled  = n_dot ? n_min_q : (n_min_q << 3) + (n_min_q << 1);

        if (i_ctl.deg_field && !n_end) begin
            if (is_digit) begin
                n_deg = (n_deg << 3) + (n_deg << 1) + 34'(deg_step);
            end else begin
                n_end = 1'b1;
            end
        end else if (i_ctl.min_field && !n_end) begin
            if (is_digit) begin
                n_min_q = q_scaled + 48'(q_step) + 48'(rem_carry);
                n_min_r = 10'(rem_sum - 14'(rem_carry) * 14'(MIN_DIV));
                if (n_dot && n_frac != 4'hF) begin
                    n_frac = n_frac + 4'd1;
                end
            end else if (i_char == CH_DOT && !n_dot) begin
                n_dot = 1'b1;
            end else begin
                n_end = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end  <= 1'b0;
            r_dot  <= 1'b0;
            r_frac <= 4'd0;
        end else if (i_ctl.en) begin
            r_end  <= n_end;
            r_dot  <= n_dot;
            r_frac <= n_frac;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_deg   <= n_deg;
            r_min_q <= n_min_q;
            r_min_r <= n_min_r;
        end
    end

    // round half up on the minutes term
    assign o_magnitude = 49'(r_deg) + 49'(r_min_q) + 49'(r_min_r >= MIN_HALF);

endmodule

// ===== src/gps_info_line_coordinate_parser.sv =====
// gps_info_line_coordinate_parser: top level of the report line parser:
// prefix check, hemisphere handling, stored position and result buffer.
// Depends on gpsinfo_pkg and gpsinfo_field_acc.
//
//  port group  dir  width  contents
//  s_axis      in   8      tdata: char_in [7:0]; tlast: end_of_line
//  m_axis      out  72     tdata: latitude [30:0], longitude [62:31],
//                          parse_status [65:63], zero [71:66]
//
// One byte is taken per cycle while tready is high; each byte goes through one register stage.
// The result of a line is registered when the byte marked tlast is accepted.
// Results sit in an output register backed by one skid register, so the
// input keeps flowing while one result waits; tready drops only while
// the skid register is full.
// Reset is synchronous: empty buffers, position 0, latitude 0, longitude 180.
module gps_info_line_coordinate_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata    // latitude, longitude, parse_status, pad
);
    import gpsinfo_pkg::*;

    logic               r_out_valid, r_skid_valid;
    logic [71:0]        r_out_data, r_skid_data;
    logic [5:0]         r_pos, n_pos;
    logic               r_prefix_ok, n_prefix_ok;
    t_status            r_status, n_status, res_status;
    logic signed [30:0] r_lat, n_lat;
    logic signed [31:0] r_lon, n_lon;

    logic        accept, push, pop, live;
    logic [7:0]  ch;
    t_field_ctl  field_ctl;
    logic [48:0] magnitude;
    logic [29:0] lat_sat;
    logic [30:0] lon_sat;
    logic [71:0] res_data;

    assign ch            = s_axis_tdata;
    assign s_axis_tready = !r_skid_valid;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign push          = accept && s_axis_tlast;
    assign pop           = r_out_valid && m_axis_tready;

    assign field_ctl.en        = accept;
    assign field_ctl.clr_deg   = (r_pos == POS_LAT_DEG) || (r_pos == POS_LON_DEG);
    assign field_ctl.clr_min   = (r_pos == POS_LAT_MIN) || (r_pos == POS_LON_MIN);
    assign field_ctl.deg_field = (r_pos >= POS_LAT_DEG && r_pos <= POS_LAT_DEG_END)
                              || (r_pos >= POS_LON_DEG && r_pos <= POS_LON_DEG_END);
    assign field_ctl.min_field = (r_pos >= POS_LAT_MIN && r_pos <= POS_LAT_MIN_END)
                              || (r_pos >= POS_LON_MIN && r_pos <= POS_LON_MIN_END);

    gpsinfo_field_acc u_field_acc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (field_ctl),
        .i_char      (ch),
        .o_magnitude (magnitude)
    );

    assign lat_sat = (magnitude > 49'(LAT_LIMIT)) ? LAT_LIMIT : magnitude[29:0];
    assign lon_sat = (magnitude > 49'(LON_LIMIT)) ? LON_LIMIT : magnitude[30:0];

    always_comb begin
        n_prefix_ok = r_prefix_ok;
        if (r_pos < 6'(PREFIX_LEN) && ch != prefix_char(r_pos[3:0])) begin
            n_prefix_ok = 1'b0;
        end
        live     = n_prefix_ok && (r_status == ST_OK);
        n_status = r_status;
        n_lat    = r_lat;
        n_lon    = r_lon;
        if (r_pos == POS_LAT_HEMI && live) begin
            if (ch == CH_S) begin
                n_lat = -$signed({1'b0, lat_sat});
            end else if (ch == CH_N) begin
                n_lat = $signed({1'b0, lat_sat});
            end else begin
                n_status = ST_BAD_NS;
            end
        end else if (r_pos == POS_LON_HEMI && live) begin
            if (ch == CH_W) begin
                n_lon = -$signed({1'b0, lon_sat});
            end else if (ch == CH_E) begin
                n_lon = $signed({1'b0, lon_sat});
            end else begin
                n_status = ST_BAD_EW;
            end
        end
        n_pos = (r_pos == POS_MAX) ? r_pos : r_pos + 6'd1;

        priority if (!n_prefix_ok || n_pos < 6'(PREFIX_LEN)) begin
            res_status = ST_PREFIX;
        end else if (n_status != ST_OK) begin
            res_status = n_status;
        end else if (n_pos < POS_FULL_LINE) begin
            res_status = ST_SHORT;
        end else begin
            res_status = ST_OK;
        end
        res_data = {6'd0, res_status, n_lon, n_lat};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= 6'd0;
            r_prefix_ok <= 1'b1;
            r_status    <= ST_OK;
            r_lat       <= '0;
            r_lon       <= $signed(LON_RESET);
        end else if (accept) begin
            r_lat <= n_lat;
            r_lon <= n_lon;
            if (s_axis_tlast) begin
                // per-line state restarts, stored latitude and longitude are kept
                r_pos       <= 6'd0;
                r_prefix_ok <= 1'b1;
                r_status    <= ST_OK;
            end else begin
                r_pos       <= n_pos;
                r_prefix_ok <= n_prefix_ok;
                r_status    <= n_status;
            end
        end
    end

    // output register plus skid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (push) begin
            if (!r_out_valid || pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out_data <= r_skid_data;
            end
        end else if (push) begin
            if (!r_out_valid || pop) begin
                r_out_data <= res_data;
            end else begin
                r_skid_data <= res_data;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register full while output register empty");

    a_line_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> (r_pos == 6'd0 && r_prefix_ok && r_status == ST_OK))
        else $error("line state not cleared after end of line");

    a_lat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lat <= $signed({1'b0, LAT_LIMIT})) && (r_lat >= -$signed({1'b0, LAT_LIMIT})))
        else $error("stored latitude out of range");

    a_prefix_fail_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_prefix_ok |-> r_pos != 6'd0)
        else $error("prefix mismatch flagged before any byte");

    a_status_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[65:63] <= ST_SHORT)
        else $error("result status code out of range");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// testbench: self-checking bench for the gps info line parser, byte stream in, position report out.
// Depends on gpsinfo_pkg and gps_info_line_coordinate_parser.
module testbench;
    import gpsinfo_pkg::*;

    localparam int BYTE_TARGET    = 1950;
    localparam int CYCLE_LIMIT    = 600000;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES   = 10;
    localparam int MAX_PRINTS     = 40;

    // predicts the report for each line and checks the block's reports in order
    class gps_report_scoreboard;
        typedef struct {
            logic signed [30:0] lat;
            logic signed [31:0] lon;
            t_status            status;
        } report_t;

        report_t expected_reports[$];
        int      mismatches = 0;
        int      reports_checked = 0;
        int      status_seen[5] = '{default: 0};

        string              prefix_text = "+CGPSINFO: ";
        logic [5:0]         line_pos = '0;
        bit                 prefix_ok = 1'b1;
        logic [9:0]         deg_acc = '0;
        logic [31:0]        min_acc = '0;
        bit                 num_done = 1'b0;
        bit                 dot_seen = 1'b0;
        logic [3:0]         frac_digits = '0;
        logic signed [30:0] lat_stored = '0;
        logic signed [31:0] lon_stored = LON_RESET;
        t_status            line_st = ST_OK;

        function void clear_number();
            min_acc     = '0;
            num_done    = 1'b0;
            dot_seen    = 1'b0;
            frac_digits = '0;
        endfunction

        function void clear_line();
            line_pos  = '0;
            prefix_ok = 1'b1;
            deg_acc   = '0;
            line_st   = ST_OK;
            clear_number();
        endfunction

        function bit is_digit(logic [7:0] ch);
            return ch >= CH_0 && ch <= CH_9;
        endfunction

        // degrees plus rounded minutes/60, in 1e-7 degree, clipped to the limit
        function logic [31:0] coord_value(bit negative, longint unsigned limit);
            longint unsigned scaled;
            longint unsigned mag;
            logic [31:0]     m32;
            int              fd;
            fd = (frac_digits > 8) ? 8 : int'(frac_digits);
            scaled = min_acc;
            repeat (8 - fd) scaled = scaled * 10;
            mag = deg_acc;
            mag = mag * 10000000 + (scaled + 300) / 600;
            if (mag > limit)
                mag = limit;
            m32 = mag[31:0];
            return negative ? -m32 : m32;
        endfunction

        function void note_byte(logic [7:0] ch, logic eol);
            logic [5:0]  p;
            bit          live;
            logic [31:0] v;
            t_status     st;
            report_t     r;
            p = line_pos;
            if (p < PREFIX_LEN && ch != prefix_text[p])
                prefix_ok = 1'b0;
            live = prefix_ok && line_st == ST_OK;
            if (p == POS_LAT_DEG || p == POS_LON_DEG) begin
                deg_acc = '0;
                clear_number();
            end
            if (p == POS_LAT_MIN || p == POS_LON_MIN)
                clear_number();
            if ((p >= POS_LAT_DEG && p <= POS_LAT_DEG_END) ||
                (p >= POS_LON_DEG && p <= POS_LON_DEG_END)) begin
                if (!num_done) begin
                    if (is_digit(ch))
                        deg_acc = 10'(deg_acc * 10 + ch - CH_0);
                    else
                        num_done = 1'b1;
                end
            end else if ((p >= POS_LAT_MIN && p <= POS_LAT_MIN_END) ||
                         (p >= POS_LON_MIN && p <= POS_LON_MIN_END)) begin
                if (!num_done) begin
                    if (is_digit(ch)) begin
                        min_acc = min_acc * 10 + (ch - CH_0);
                        if (dot_seen && frac_digits < 15)
                            frac_digits++;
                    end else if (ch == CH_DOT && !dot_seen) begin
                        dot_seen = 1'b1;
                    end else begin
                        num_done = 1'b1;
                    end
                end
            end else if (p == POS_LAT_HEMI && live) begin
                if (ch == CH_S || ch == CH_N) begin
                    v = coord_value(ch == CH_S, LAT_LIMIT);
                    lat_stored = v[30:0];
                end else begin
                    line_st = ST_BAD_NS;
                end
            end else if (p == POS_LON_HEMI && live) begin
                if (ch == CH_W || ch == CH_E)
                    lon_stored = coord_value(ch == CH_W, LON_LIMIT);
                else
                    line_st = ST_BAD_EW;
            end
            if (line_pos < POS_MAX)
                line_pos++;
            if (eol) begin
                if (!prefix_ok || line_pos < PREFIX_LEN)
                    st = ST_PREFIX;
                else if (line_st != ST_OK)
                    st = line_st;
                else if (line_pos < POS_FULL_LINE)
                    st = ST_SHORT;
                else
                    st = ST_OK;
                r.lat    = lat_stored;
                r.lon    = lon_stored;
                r.status = st;
                expected_reports.push_back(r);
                clear_line();
            end
        endfunction

        function void flag_mismatch(string field, longint expv, longint gotv);
            mismatches++;
            if (mismatches <= MAX_PRINTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, expv, gotv);
        endfunction

        function void check_report(logic [71:0] d);
            report_t r;
            if (expected_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_PRINTS)
                    $display("%0t: report with none expected, expected nothing, actual lat %0d lon %0d status %0d",
                             $time, $signed(d[30:0]), $signed(d[62:31]), d[65:63]);
                return;
            end
            r = expected_reports.pop_front();
            reports_checked++;
            status_seen[r.status]++;
            if (d[30:0] !== r.lat)
                flag_mismatch("latitude", r.lat, $signed(d[30:0]));
            if (d[62:31] !== r.lon)
                flag_mismatch("longitude", r.lon, $signed(d[62:31]));
            if (d[65:63] !== r.status)
                flag_mismatch("status", longint'(r.status), d[65:63]);
            if (d[71:66] !== '0)
                flag_mismatch("pad bits", 0, d[71:66]);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;    // [7:0] char_in
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;         // [30:0] latitude, [62:31] longitude, [65:63] status

    gps_report_scoreboard position_check;
    logic [7:0] line_buf[$];
    int         lines_sent = 0;
    int         bytes_sent = 0;
    int         cycle_count = 0;
    bit         line_no_idle = 1'b0;
    bit         rx_hold_req = 1'b0;

    gps_info_line_coordinate_parser DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("run stopped at cycle limit %0d with %0d reports outstanding",
                     CYCLE_LIMIT, position_check.expected_reports.size());
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            position_check.check_report(m_axis_tdata);
    end

    // receiver: random ready with bursts, stalls, and one long hold-off on request
    initial begin
        int stretch;
        int mode;
        int r;
        stretch = 0;
        mode    = 0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                m_axis_tready = 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge i_clk);
                rx_hold_req = 1'b0;
            end
            if (stretch == 0) begin
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    mode    = 0;
                    stretch = $urandom_range(5, 60);
                end else if (r < 90) begin
                    mode    = 1;
                    stretch = $urandom_range(5, 40);
                end else begin
                    mode    = 2;
                    stretch = $urandom_range(10, 50);
                end
            end
            stretch--;
            case (mode)
                0:       m_axis_tready = 1'b1;
                1:       m_axis_tready = ($urandom_range(0, 99) < 70);
                default: m_axis_tready = 1'b0;
            endcase
        end
    end

    function int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (line_no_idle || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    task automatic send_byte(input logic [7:0] ch, input logic eol);
        int gap;
        gap = idle_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = ch;
        s_axis_tlast  = eol;
        do @(posedge i_clk); while (!s_axis_tready);
        position_check.note_byte(ch, eol);
        bytes_sent++;
    endtask

    task automatic send_line();
        line_no_idle = ($urandom_range(0, 3) == 0);
        foreach (line_buf[i])
            send_byte(line_buf[i], i == line_buf.size() - 1);
        lines_sent++;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    task automatic send_text(input string s);
        line_buf.delete();
        add_text(s);
        send_line();
    endtask

    task automatic add_degrees(input int n);
        int r;
        r = $urandom_range(0, 99);
        repeat (n) begin
            if (r < 85)
                line_buf.push_back(8'(CH_0 + $urandom_range(0, 9)));
            else if (r < 93)
                line_buf.push_back(CH_9);
            else
                line_buf.push_back(CH_0);
        end
    endtask

    // nine bytes of minutes: mostly mm.mmmmmm, sometimes a moved dot, no dot or junk
    task automatic add_minutes();
        int kind;
        int dot_at;
        kind   = $urandom_range(0, 99);
        dot_at = (kind < 65) ? 2 : (kind < 85) ? $urandom_range(0, 8) : -1;
        for (int i = 0; i < 9; i++) begin
            if (i == dot_at)
                line_buf.push_back(CH_DOT);
            else if (kind >= 93 && $urandom_range(0, 5) == 0)
                line_buf.push_back($urandom_range(0, 1) ? CH_DOT : 8'($urandom_range(0, 255)));
            else
                line_buf.push_back(8'(CH_0 + $urandom_range(0, 9)));
        end
    endtask

    function logic [7:0] pick_hemi(input logic [7:0] a, input logic [7:0] b);
        int r;
        r = $urandom_range(0, 99);
        if (r < 46)
            return a;
        else if (r < 92)
            return b;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    task automatic build_report_line();
        int n;
        line_buf.delete();
        add_text("+CGPSINFO: ");
        add_degrees(2);
        add_minutes();
        add_text(",");
        line_buf.push_back(pick_hemi(CH_N, CH_S));
        add_text(",");
        add_degrees(3);
        add_minutes();
        add_text(",");
        line_buf.push_back(pick_hemi(CH_E, CH_W));
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 45) : $urandom_range(0, 20);
        repeat (n) line_buf.push_back(8'($urandom_range(32, 126)));
        if ($urandom_range(0, 99) < 15)
            line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 10) begin
            n = $urandom_range(1, line_buf.size() - 1);
            while (line_buf.size() > n)
                void'(line_buf.pop_back());
        end
    endtask

    task automatic build_noise_line();
        int n;
        line_buf.delete();
        if ($urandom_range(0, 1))
            add_text("+CGPSINFO: ");
        n = $urandom_range(1, 70);
        repeat (n) begin
            if ($urandom_range(0, 1))
                line_buf.push_back(8'($urandom_range(0, 255)));
            else
                line_buf.push_back(8'(CH_0 + $urandom_range(0, 9)));
        end
    endtask

    initial begin
        position_check = new;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed lines
        send_text("+CGPSINFO: 3113.343286,N,12121.234064,E,250311,072809.3,44.1,0.0,0");
        send_text("+CGPSINFO: 9000.000000,S,18000.000000,W,");
        send_text("+CGPSINFO: 9959.999999,N,99959.999999,E");
        send_text("+CGPSINFO: 0000.000000,S,00000.000000,W,x");
        send_text("+CGPSINFO: 4530.000000,Q,00730.000000,E,");
        send_text("+CGPSINFO: 4530.000000,N,00730.000000,e,");
        send_text("+CGPSINFO: 4810.500000,N,0112");
        send_text("+CGPSINF0: 4810.500000,N,01122.000000,E,");
        send_text("+CGPS");
        // second dot, letters and a blank ahead of the digits
        send_text("+CGPSINFO: 1.34.5.6789,N,ab  12.34567,W,");
        // minutes without a dot, then minutes that open with the dot
        send_text("+CGPSINFO: 12345678901,N,123456789012,E,");
        send_text("+CGPSINFO: 05.12345678,S,000.12345678,W,");
        // position counter saturation
        send_text("+CGPSINFO: 3113.343286,N,12121.234064,E,250311,072809.3,44.1,0.0,0,abcdefghijklmnop");
        line_buf.delete();
        line_buf.push_back(8'hFF);
        line_buf.push_back(8'h00);
        send_line();
        line_buf.delete();
        line_buf.push_back(8'h00);
        send_line();

        // random lines; the receiver holds off once at the start so the block backs up
        rx_hold_req = 1'b1;
        while (bytes_sent < BYTE_TARGET) begin
            if ($urandom_range(0, 99) < 75)
                build_report_line();
            else
                build_noise_line();
            send_line();
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        s_axis_tlast  = 1'b0;

        while (position_check.expected_reports.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d lines (%0d bytes), checked %0d position reports",
                 lines_sent, bytes_sent, position_check.reports_checked);
        $display("report status mix: ok %0d, prefix %0d, bad N/S %0d, bad E/W %0d, short %0d",
                 position_check.status_seen[ST_OK], position_check.status_seen[ST_PREFIX],
                 position_check.status_seen[ST_BAD_NS], position_check.status_seen[ST_BAD_EW],
                 position_check.status_seen[ST_SHORT]);
        if (position_check.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
